// ===== rtl/rqks_pkg.sv =====
// ---------------------------------------------------------------------------
// rqks_pkg
// Shared types and codes for the ring queue with unique key search.
// ---------------------------------------------------------------------------
`default_nettype none
package rqks_pkg;
  localparam int NCOURSE = 5;
  localparam int CRS_W   = 16;
  localparam int PAY_W   = 32;
  localparam int CNT_W   = 7;

  localparam logic [2:0] OP_ENQ = 3'd0;
  localparam logic [2:0] OP_DEQ = 3'd1;
  localparam logic [2:0] OP_LKP = 3'd2;
  localparam logic [2:0] OP_CNT = 3'd3;
  localparam logic [2:0] OP_DEL = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_REPEAT  = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // capture the input beat, point walker at oldest
    logic step;     // compare current entry, advance walker
    logic shift;    // delete: copy next entry into current slot, advance
    logic write;    // enqueue: write record at write slot
    logic pop;      // dequeue: advance read slot
    logic del_fix;  // delete finished: retreat write slot, drop count
    logic rd_out;   // capture record at walker into result
    logic done;     // present result
    logic [2:0] st; // status to present
  } rqks_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic last;     // walker is on the newest record
    logic hit;      // key at walker matches
    logic [2:0] op;
  } rqks_sts_t;
endpackage
`default_nettype wire

// ===== rtl/rqks_dp.sv =====
// ---------------------------------------------------------------------------
// rqks_dp
// Record storage, ring pointers, walker and result registers.
// ---------------------------------------------------------------------------
`default_nettype none
module rqks_dp import rqks_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int KEY_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [4:0]       cfg_wdata,
  input  wire logic [2:0]       in_op,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [PAY_W-1:0] in_payload,
  input  wire logic [NCOURSE*CRS_W-1:0] in_courses,
  input  wire logic [CRS_W-1:0] in_search_course,
  input  rqks_cmd_t             cmd,
  output rqks_sts_t             sts,
  output logic                  out_strobe,
  output logic [2:0]            out_status,
  output logic [KEY_W-1:0]      out_found_key,
  output logic [PAY_W-1:0]      out_found_payload,
  output logic [NCOURSE*CRS_W-1:0] out_found_courses,
  output logic [CNT_W-1:0]      out_match_count,
  output logic [4:0]            out_occupancy
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW = $clog2(DEPTH + 1);
  localparam int RW = KEY_W + PAY_W + NCOURSE*CRS_W;

  // record memory, one word per slot
  logic [RW-1:0] mem [DEPTH];

  logic [4:0]       cap_r;
  logic [AW-1:0]    wr_r, rd_r, wk_r;
  logic [HW-1:0]    held_r, pos_r;
  logic [2:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] pay_r;
  logic [NCOURSE*CRS_W-1:0] crs_r;
  logic [CRS_W-1:0] srch_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RW-1:0]    rdat_r;

  // effective capacity, clipped to 1..DEPTH
  logic [HW-1:0] ecap;
  always_comb begin
    if (cap_r == 5'd0) ecap = HW'(1);
    else if (32'(cap_r) > DEPTH) ecap = HW'(DEPTH);
    else ecap = HW'(cap_r);
  end

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] s, input logic [HW-1:0] c);
    logic [HW:0] n;
    n = (HW+1)'(s) + 1'b1;
    return (n >= (HW+1)'(c)) ? '0 : AW'(n);
  endfunction

  logic [AW-1:0] wk_n;
  assign wk_n = nxt(wk_r, ecap);

  // tag matches in the entry at the walker
  logic [3:0] tag_hits;
  always_comb begin
    tag_hits = '0;
    for (int c = 0; c < NCOURSE; c++)
      if (mem[wk_r][c*CRS_W +: CRS_W] == srch_r) tag_hits = tag_hits + 4'd1;
  end

  assign sts.empty = (held_r == '0);
  assign sts.full  = (held_r >= ecap);
  assign sts.last  = (pos_r + 1'b1 >= held_r);
  assign sts.hit   = (mem[wk_r][RW-1 -: KEY_W] == key_r);
  assign sts.op    = op_r;

  // memory write: enqueue or delete shift
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[(HW'(wr_r) >= ecap) ? '0 : wr_r] <= {key_r, pay_r, crs_r};
    end else if (cmd.shift) begin
      mem[wk_r] <= mem[wk_n];
    end
    rdat_r <= mem[wk_r];
  end

  // pointers and walker
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      wr_r <= '0; rd_r <= '0; held_r <= '0; wk_r <= '0; pos_r <= '0;
      cnt_r <= '0; op_r <= OP_ENQ;
    end else begin
      if (cmd.load) begin
        op_r <= in_op; key_r <= in_key; pay_r <= in_payload;
        crs_r <= in_courses; srch_r <= in_search_course;
        wk_r <= rd_r; pos_r <= '0; cnt_r <= '0;
      end
      if (cmd.step || cmd.shift) begin
        wk_r <= wk_n; pos_r <= pos_r + 1'b1;
        if (cmd.step && op_r == OP_CNT) begin
          if (cnt_r + CNT_W'(tag_hits) < cnt_r || (cnt_r + CNT_W'(tag_hits) > 7'd127))
            cnt_r <= 7'd127;
          else cnt_r <= cnt_r + CNT_W'(tag_hits);
        end
      end
      if (cmd.write) begin
        wr_r <= nxt((HW'(wr_r) >= ecap) ? '0 : wr_r, ecap);
        held_r <= held_r + 1'b1;
      end
      if (cmd.pop) begin
        rd_r <= nxt(rd_r, ecap); held_r <= held_r - 1'b1;
      end
      if (cmd.del_fix) begin
        wr_r <= (wr_r == '0) ? AW'(ecap - 1'b1) : wr_r - 1'b1;
        held_r <= held_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= 5'd16;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  // result register; a dequeue reports the count after its pop
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= cmd.done;
    if (cmd.done) begin
      out_status <= cmd.st;
      {out_found_key, out_found_payload, out_found_courses} <=
        cmd.rd_out ? rdat_r : '0;
      out_match_count <= (op_r == OP_CNT) ? cnt_r : '0;
      out_occupancy <= cmd.pop ? 5'(held_r - 1'b1) : 5'(held_r);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rqks_ctrl.sv =====
// ---------------------------------------------------------------------------
// rqks_ctrl
// Sequencer: walks the ring for search, count, delete and the enqueue key check.
// ---------------------------------------------------------------------------
`default_nettype none
module rqks_ctrl import rqks_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  rqks_sts_t sts,
  output rqks_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_CNT  = 3'd3;
  localparam logic [2:0] S_SHFT = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] st_r, st_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    st_nxt = st_r;
    unique case (state_r)
      S_IDLE: if (start) begin cmd.load = 1'b1; state_nxt = S_DEC; end
      S_DEC: begin
        st_nxt = ST_OK;
        priority if (sts.op == OP_ENQ) begin
          if (sts.full) begin st_nxt = ST_FULL; state_nxt = S_FIN; end
          else if (sts.empty) begin cmd.write = 1'b1; state_nxt = S_FIN; end
          else state_nxt = S_SRCH;
        end else if (sts.op > OP_DEL) begin
          state_nxt = S_FIN;
        end else if (sts.empty) begin
          st_nxt = ST_EMPTY; state_nxt = S_FIN;
        end else if (sts.op == OP_DEQ) begin
          state_nxt = S_RD;
        end else if (sts.op == OP_CNT) begin
          state_nxt = S_CNT;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      // key search over held records
      S_SRCH: begin
        priority if (sts.hit) begin
          priority if (sts.op == OP_ENQ) begin
            st_nxt = ST_REPEAT; state_nxt = S_FIN;
          end else if (sts.op == OP_LKP) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_SHFT;
          end
        end else if (sts.last) begin
          if (sts.op == OP_ENQ) cmd.write = 1'b1;
          else st_nxt = ST_MISSING;
          state_nxt = S_FIN;
        end else cmd.step = 1'b1;
      end
      S_CNT: begin
        cmd.step = 1'b1;
        if (sts.last) state_nxt = S_FIN;
      end
      // close the gap one entry per cycle
      S_SHFT: begin
        if (sts.last) begin cmd.del_fix = 1'b1; state_nxt = S_FIN; end
        else cmd.shift = 1'b1;
      end
      // read data register already holds the record at the walker
      S_RD: begin
        if (sts.op == OP_DEQ) cmd.pop = 1'b1;
        state_nxt = S_IDLE;
        cmd.done = 1'b1; cmd.rd_out = 1'b1; cmd.st = ST_OK;
      end
      S_FIN: begin
        cmd.done = 1'b1;
        cmd.st = st_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and pending status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; st_r <= ST_OK;
    end else begin
      state_r <= state_nxt; st_r <= st_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ring_queue_unique_key_search.sv =====
// ---------------------------------------------------------------------------
// ring_queue_unique_key_search
// Circular record queue with unique keys, lookup, tag count and delete.
// ---------------------------------------------------------------------------
// channel   | handshake           | fields
// input     | start / busy        | in_op, in_key, in_payload, in_course_*, ...
// result    | out_strobe (1 cyc)  | out_status, out_found_*, out_match_count, ...
// config    | cfg_we              | cfg_wdata (capacity)
//
// Dequeue, enqueue into empty, full, empty answers and unknown ops skip the walk;
// search, count and enqueue walk up to all held records; delete walks, then shifts.
// Beat time is set by the single-entry walk over the record memory.
// Reset is synchronous and empties the queue; capacity returns to 16.
// Results cannot be stalled; busy stays high until the result strobe.
`default_nettype none
module ring_queue_unique_key_search import rqks_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int KEY_W = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [15:0] in_key,
  input  wire logic [31:0] in_payload,
  input  wire logic [15:0] in_course_0,
  input  wire logic [15:0] in_course_1,
  input  wire logic [15:0] in_course_2,
  input  wire logic [15:0] in_course_3,
  input  wire logic [15:0] in_course_4,
  input  wire logic [15:0] in_search_course,
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [15:0]      out_found_key,
  output logic [31:0]      out_found_payload,
  output logic [15:0]      out_found_course_0,
  output logic [15:0]      out_found_course_1,
  output logic [15:0]      out_found_course_2,
  output logic [15:0]      out_found_course_3,
  output logic [15:0]      out_found_course_4,
  output logic [6:0]       out_match_count,
  output logic [4:0]       out_occupancy
);
  rqks_cmd_t cmd;
  rqks_sts_t sts;
  logic [KEY_W-1:0] fkey;
  logic [NCOURSE*CRS_W-1:0] fcrs;
  logic [2:0] dp_status;
  logic in_op_cnt_r;

  rqks_ctrl u_ctrl (.clk, .rst_n, .start(start && !cfg_we), .busy, .sts, .cmd);

  rqks_dp #(.DEPTH(DEPTH), .KEY_W(KEY_W)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_op, .in_key(KEY_W'(in_key)), .in_payload,
    .in_courses({in_course_0, in_course_1, in_course_2, in_course_3, in_course_4}),
    .in_search_course, .cmd, .sts, .out_strobe, .out_status(dp_status),
    .out_found_key(fkey), .out_found_payload, .out_found_courses(fcrs),
    .out_match_count, .out_occupancy
  );

  // count with no match reports not found
  assign out_status = (dp_status == ST_OK && in_op_cnt_r && out_match_count == '0)
                      ? ST_MISSING : dp_status;
  always_ff @(posedge clk) begin
    if (cmd.done) in_op_cnt_r <= (sts.op == OP_CNT);
  end

  assign out_found_key = 16'(fkey);
  assign {out_found_course_0, out_found_course_1, out_found_course_2,
          out_found_course_3, out_found_course_4} = fcrs;
endmodule
`default_nettype wire

// ===== rtl/rqks_chk.sv =====
// ---------------------------------------------------------------------------
// rqks_chk
// Port-level checks for the ring queue.
// ---------------------------------------------------------------------------
`default_nettype none
module rqks_chk import rqks_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       cfg_we,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_strobe,
  input wire logic [2:0] out_status,
  input wire logic [4:0] out_occupancy
);
  // an accepted beat makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !cfg_we |=> busy) else $error("busy not raised");
  // strobe is a single cycle
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe held");
  // status code is in range
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_status <= ST_MISSING) else $error("bad status");
  // occupancy never beyond sixteen
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_occupancy <= 5'd16) else $error("bad occupancy");
endmodule

bind ring_queue_unique_key_search rqks_chk u_chk (.clk, .rst_n, .cfg_we, .start, .busy,
  .out_strobe, .out_status, .out_occupancy);
`default_nettype wire
